>>> hdl/lcdnw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, request codes and constant tables for the 4-bit character
// LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    // request codes
    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_CMD     = 3'd1;
    localparam logic [2:0] OP_CHAR    = 3'd2;
    localparam logic [2:0] OP_CURSOR  = 3'd3;
    localparam logic [2:0] OP_DECIMAL = 3'd4;

    // decimal digit count limits
    localparam logic [2:0] DIGITS_MIN = 3'd2;
    localparam logic [2:0] DIGITS_MAX = 3'd5;
    localparam int         NUM_DIGITS = 5;

    // set-DDRAM-address command and ASCII '0' high nibble
    localparam logic [7:0] CURSOR_CMD   = 8'h80;
    localparam logic [3:0] ASCII_DIG_HI = 4'h3;

    // init sequence: raw nibbles, then function set, display on, entry mode, clear
    localparam logic [3:0] INIT_NIB  [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
    localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h0C, 8'h06, 8'h01};
    localparam logic [3:0] INIT_RAW_STROBES = 4'd4;
    localparam logic [3:0] INIT_STROBES     = 4'd12;
    localparam logic [3:0] BYTE_STROBES     = 4'd2;

    // number mod 100000: 100000 = 32 * 3125, quotient by reciprocal of 3125
    localparam int          DIV_SHIFT   = 5;
    localparam logic [27:0] RECIP_M     = 28'd175921861;
    localparam int          RECIP_SHIFT = 39;
    localparam logic [16:0] DEC_MOD     = 17'd100000;

    // digit weights for the extraction stages, most significant first
    localparam logic [16:0] DIG_WEIGHT [4] = '{17'd10000, 17'd1000, 17'd100, 17'd10};

    // pipeline depth in front of the strobe serializer
    localparam int PIPE_STAGES = 8;

    // one pipeline stage word
    typedef struct packed {
        logic [2:0]            op;
        logic [7:0]            byte_val;
        logic [2:0]            digit_count;
        logic [31:0]           work;
        logic [54:0]           prod;
        logic [4:0][3:0]       digits;
    } pl_t;

    // finished request handed to the serializer
    typedef struct packed {
        logic [2:0]            op;
        logic [7:0]            byte_val;
        logic [2:0]            digit_count;
        logic [4:0][3:0]       digits;
    } req_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [16:0] rem;
    } dsplit_t;

    // one decimal digit of value by weight, value below ten times weight
    function automatic dsplit_t digit_split(input logic [16:0] value,
                                            input logic [16:0] weight);
        dsplit_t     res;
        logic [16:0] step;
        res.digit = 4'd0;
        res.rem   = value;
        for (int k = 1; k < 10; k++) begin
            step = 17'(k) * weight;
            if (value >= step) begin
                res.digit = 4'(k);
                res.rem   = value - step;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/lcdnw_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_serializer
// Holds one finished request and issues its nibble strobes, one per cycle
// while m_ready does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module lcdnw_serializer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            req_valid,
    input  wire lcdnw_pkg::req_t req,
    output logic                 req_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_reg_select,
    output logic [3:0]           m_nibble,
    output logic                 m_last
);
    import lcdnw_pkg::*;

    req_t       hold_reg;
    logic       busy_reg;
    logic [3:0] idx_reg;
    logic [3:0] total_reg;
    logic [3:0] total_next;
    logic       m_valid_reg;
    logic       m_rs_reg;
    logic [3:0] m_nib_reg;
    logic       m_last_reg;

    logic       out_ok;
    logic       emit;
    logic       at_last;
    logic       load;
    logic       cur_rs;
    logic [7:0] cur_byte;
    logic [3:0] cur_nib;
    logic [3:0] idx_m4;
    logic [2:0] dig_pos;

    // output stage can take a strobe
    assign out_ok  = !m_valid_reg || m_ready;
    assign emit    = busy_reg && out_ok;
    assign at_last = (idx_reg == total_reg - 4'd1);
    assign req_ready = !busy_reg || (emit && at_last);
    assign load    = req_valid && req_ready;

    // strobe count of the incoming request
    always_comb begin
        unique case (req.op)
            OP_INIT:    total_next = INIT_STROBES;
            OP_DECIMAL: total_next = {req.digit_count, 1'b0};
            default:    total_next = BYTE_STROBES;
        endcase
    end

    // current strobe from the held request and the strobe index
    always_comb begin
        idx_m4  = idx_reg - INIT_RAW_STROBES;
        dig_pos = 3'(hold_reg.digit_count - 3'd1 - idx_reg[3:1]);
        cur_rs   = 1'b0;
        cur_byte = hold_reg.byte_val;
        unique case (hold_reg.op)
            OP_INIT: begin
                cur_byte = INIT_CMDS[idx_m4[2:1]];
            end
            OP_CMD, OP_CURSOR: begin
                cur_rs = 1'b0;
            end
            OP_CHAR: begin
                cur_rs = 1'b1;
            end
            OP_DECIMAL: begin
                cur_rs   = 1'b1;
                cur_byte = {ASCII_DIG_HI, hold_reg.digits[dig_pos]};
            end
            default: begin
                cur_byte = 8'd0;
            end
        endcase
        if (hold_reg.op == OP_INIT && idx_reg < INIT_RAW_STROBES) begin
            cur_nib = INIT_NIB[idx_reg[1:0]];
        end else if (idx_reg[0]) begin
            cur_nib = cur_byte[3:0];
        end else begin
            cur_nib = cur_byte[7:4];
        end
    end

    // sequencing control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end else if (emit && at_last) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request hold and output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg  <= req;
            total_reg <= total_next;
        end
        if (emit) begin
            m_rs_reg   <= cur_rs;
            m_nib_reg  <= cur_nib;
            m_last_reg <= at_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = m_rs_reg;
    assign m_nibble     = m_nib_reg;
    assign m_last       = m_last_reg;

    // index stays inside the request
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < total_reg)
        else $error("strobe index beyond request length");

    // no new request while strobes remain
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !(emit && at_last) |-> !req_ready)
        else $error("request taken while strobes remain");

    // a loaded request starts at its first strobe
    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && idx_reg == 4'd0)
        else $error("request load did not restart sequencing");

    // init opens with a raw nibble three on the instruction register
    a_init_first: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && hold_reg.op == OP_INIT && idx_reg == 4'd0
        |=> m_valid && m_nibble == INIT_NIB[0] && !m_reg_select && !m_last)
        else $error("init sequence first strobe wrong");

endmodule
`default_nettype wire

>>> hdl/char_lcd_nibble_write_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top
// Turns LCD requests into register-select plus D7..D4 strobes of a 4-bit bus.
//
// Usage: the s_ channel takes one request per transaction (op, byte_value,
// cursor_address, number, digit_count). The m_ channel gives one transaction
// per enable strobe, high nibble first, with m_last on the final strobe of a
// request. Init makes 12 strobes, command, character and cursor make 2, and a
// decimal request makes 2 * digit_count (digit_count saturated to 2..5).
// Op codes 5 to 7 are accepted and produce nothing.
// The first strobe of a request passes eight pipeline stages (prepare, two
// multiplies for mod 100000, subtract, four digit stages), then the
// serializer's hold register and its output register.
// Throughput: one strobe per cycle while m_ready does not stall; the serializer
// takes the next request while it issues the last strobe of the current one,
// so requests are taken back to back.
// Reset (aresetn low, synchronous) empties the pipeline and output stage.
// A stall on m_ready holds the output strobe and backs up the pipeline stage
// by stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic [6:0]  s_cursor_address,
    input  wire logic [31:0] s_number,
    input  wire logic [2:0]  s_digit_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_reg_select,
    output logic [3:0]       m_nibble,
    output logic             m_last
);
    import lcdnw_pkg::*;

    pl_t                    st_reg  [PIPE_STAGES];
    pl_t                    st_next [PIPE_STAGES];
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vin;
    logic [PIPE_STAGES-1:0] acc;
    logic                   req_ready;
    req_t                   req;

    // stage can take a new word when empty or its word moves on
    always_comb begin
        acc[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || req_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            acc[i] = !vld_reg[i] || acc[i+1];
        end
    end

    assign s_ready = acc[0];

    // valid into each stage, unused op codes are dropped at entry
    always_comb begin
        vin[0] = s_valid && (s_op <= OP_DECIMAL);
        for (int i = 1; i < PIPE_STAGES; i++) begin
            vin[i] = vld_reg[i-1];
        end
    end

    // stage datapath
    always_comb begin
        dsplit_t sp;
        // prepare: byte to send and saturated digit count
        st_next[0].op     = s_op;
        st_next[0].work   = s_number;
        st_next[0].prod   = '0;
        st_next[0].digits = '0;
        if (s_op == OP_CURSOR) begin
            st_next[0].byte_val = CURSOR_CMD | {1'b0, s_cursor_address};
        end else begin
            st_next[0].byte_val = s_byte_value;
        end
        if (s_digit_count < DIGITS_MIN) begin
            st_next[0].digit_count = DIGITS_MIN;
        end else if (s_digit_count > DIGITS_MAX) begin
            st_next[0].digit_count = DIGITS_MAX;
        end else begin
            st_next[0].digit_count = s_digit_count;
        end

        for (int i = 1; i < PIPE_STAGES; i++) begin
            st_next[i] = st_reg[i-1];
        end

        // quotient by 100000 through reciprocal of 3125
        st_next[1].prod = {28'd0, st_reg[0].work[31:DIV_SHIFT]} * {27'd0, RECIP_M};

        // quotient times 100000
        st_next[2].prod = {39'd0, st_reg[1].prod[54:RECIP_SHIFT]} * 55'(DEC_MOD);

        // remainder below 100000 fits in 17 bits
        st_next[3].work = {15'd0, st_reg[2].work[16:0] - st_reg[2].prod[16:0]};

        // one decimal digit per stage, most significant first; the last stage also gives the units
        for (int j = 0; j < 4; j++) begin
            sp = digit_split(st_reg[3+j].work[16:0], DIG_WEIGHT[j]);
            st_next[4+j].digits[NUM_DIGITS-1-j] = sp.digit;
            st_next[4+j].work = {15'd0, sp.rem};
        end
        st_next[PIPE_STAGES-1].digits[0] = st_reg[PIPE_STAGES-2].work[3:0]
            - DIG_WEIGHT[3][3:0] * st_next[PIPE_STAGES-1].digits[1];
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < PIPE_STAGES; i++) begin
                if (acc[i]) begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < PIPE_STAGES; i++) begin
            if (acc[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // finished request
    assign req.op          = st_reg[PIPE_STAGES-1].op;
    assign req.byte_val    = st_reg[PIPE_STAGES-1].byte_val;
    assign req.digit_count = st_reg[PIPE_STAGES-1].digit_count;
    assign req.digits      = st_reg[PIPE_STAGES-1].digits;

    lcdnw_serializer u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (vld_reg[PIPE_STAGES-1]),
        .req          (req),
        .req_ready    (req_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_nibble     (m_nibble),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire

>>> dv/char_lcd_nibble_write_sequencer_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top_tb
// Self-checking testbench for the 4-bit LCD nibble write sequencer. Requests
// go in on the s_ channel and every accepted one is expanded by a behavioral
// predictor into the expected strobe list. Each strobe taken from the m_
// channel is compared field by field with the oldest expected strobe.
// Directed requests cover the corners. Random traffic follows, with random
// gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdnw_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 24;
    localparam int IDLE_WAIT_LIMIT = 100000;
    localparam int TIMEOUT_NS      = 20_000_000;

    // init command bytes and raw wake-up nibbles
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [3:0] NIB_WAKE         = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // unused request codes
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } strobe_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [7:0]  s_byte_value;
    logic [6:0]  s_cursor_address;
    logic [31:0] s_number;
    logic [2:0]  s_digit_count;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_reg_select;
    logic [3:0]  m_nibble;
    logic        m_last;

    strobe_t expected_strobes[$];
    int      mismatch_count = 0;
    int      ready_hold = 0;
    bit      gaps_on = 1'b0;
    bit      stalls_on = 1'b0;

    char_lcd_nibble_write_sequencer_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_byte_value     (s_byte_value),
        .s_cursor_address (s_cursor_address),
        .s_number         (s_number),
        .s_digit_count    (s_digit_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reg_select     (m_reg_select),
        .m_nibble         (m_nibble),
        .m_last           (m_last)
    );

    // clock
    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // strobe prediction
    function automatic void queue_strobe(input logic rs, input logic [3:0] nib);
        strobe_t s;
        s.reg_select = rs;
        s.nibble     = nib;
        s.last       = 1'b0;
        expected_strobes.push_back(s);
    endfunction

    function automatic void queue_byte(input logic rs, input logic [7:0] value);
        queue_strobe(rs, value[7:4]);
        queue_strobe(rs, value[3:0]);
    endfunction

    function automatic void predict_strobes(input logic [2:0] op, input logic [7:0] bv,
                                            input logic [6:0] addr, input logic [31:0] num,
                                            input logic [2:0] dc);
        int          first_idx;
        int          ndig;
        logic [31:0] weight;
        logic [31:0] digit;
        first_idx = expected_strobes.size();
        case (op)
            OP_INIT: begin
                queue_strobe(RS_INSTR, NIB_WAKE);
                queue_strobe(RS_INSTR, NIB_WAKE);
                queue_strobe(RS_INSTR, NIB_WAKE);
                queue_strobe(RS_INSTR, NIB_FOUR_BIT);
                queue_byte(RS_INSTR, CMD_FUNCTION_SET);
                queue_byte(RS_INSTR, CMD_DISPLAY_ON);
                queue_byte(RS_INSTR, CMD_ENTRY_MODE);
                queue_byte(RS_INSTR, CMD_CLEAR);
            end
            OP_CMD:    queue_byte(RS_INSTR, bv);
            OP_CHAR:   queue_byte(RS_DATA, bv);
            OP_CURSOR: queue_byte(RS_INSTR, CURSOR_CMD | {1'b0, addr});
            OP_DECIMAL: begin
                // digit count saturates into the legal range
                ndig = dc;
                if (ndig < DIGITS_MIN) ndig = DIGITS_MIN;
                if (ndig > DIGITS_MAX) ndig = DIGITS_MAX;
                for (int i = ndig; i > 0; i--) begin
                    weight = 32'd1;
                    for (int j = 1; j < i; j++) weight = weight * 32'd10;
                    digit = (num / weight) % 32'd10;
                    queue_byte(RS_DATA, {ASCII_DIG_HI, digit[3:0]});
                end
            end
            default: ;
        endcase
        if (expected_strobes.size() > first_idx)
            expected_strobes[expected_strobes.size() - 1].last = 1'b1;
    endfunction

    // one request transaction; entered and left at a falling edge
    task automatic send_request(input logic [2:0] op, input logic [7:0] bv,
                                input logic [6:0] addr, input logic [31:0] num,
                                input logic [2:0] dc);
        int gap;
        gap = pick_gap(gaps_on);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op             = op;
        s_byte_value     = bv;
        s_cursor_address = addr;
        s_number         = num;
        s_digit_count    = dc;
        s_valid          = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_strobes(op, bv, addr, num, dc);
        @(negedge aclk);
    endtask

    // random request, mostly legal ops; returns 0 for an ignored op
    task automatic send_random_request(output bit counted);
        logic [2:0]  op;
        logic [31:0] num;
        logic [2:0]  dc;
        int          r;
        r  = $urandom_range(99);
        op = (r < 8) ? 3'($urandom_range(OP_SPARE_5, OP_SPARE_7))
                     : 3'($urandom_range(OP_INIT, OP_DECIMAL));
        r  = $urandom_range(99);
        if (r < 40)      num = $urandom;
        else if (r < 70) num = $urandom_range(99999);
        else if (r < 85) num = $urandom_range(999);
        else             num = 32'hFFFF_FFFF - $urandom_range(200000);
        dc = ($urandom_range(99) < 85) ? 3'($urandom_range(DIGITS_MIN, DIGITS_MAX))
                                       : 3'($urandom_range(7));
        send_request(op, 8'($urandom), 7'($urandom), num, dc);
        counted = (op <= OP_DECIMAL);
    endtask

    // drop valid, wait for every expected strobe, then let the pipe settle
    task automatic wait_until_idle();
        int waited;
        waited  = 0;
        s_valid = 1'b0;
        while (expected_strobes.size() != 0 && waited < IDLE_WAIT_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (expected_strobes.size() != 0) begin
            $display("%0t: %0d expected strobes never arrived", $time,
                     expected_strobes.size());
            mismatch_count++;
            expected_strobes.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        int sent;
        bit counted;
        sent = 0;
        while (sent < count) begin
            send_random_request(counted);
            if (counted) sent++;
        end
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (stalls_on && $urandom_range(3) == 0) ready_hold <= pick_gap(1'b1);
        end
    end

    // field compare
    task automatic compare_field(input string name, input logic [3:0] expected_value,
                                 input logic [3:0] actual_value);
        if (actual_value !== expected_value) begin
            $display("%0t: %s mismatch expected %h actual %h", $time, name,
                     expected_value, actual_value);
            mismatch_count++;
        end
    endtask

    // strobe checker
    always @(posedge aclk) begin
        strobe_t exp_s;
        if (aresetn && m_valid && m_ready) begin
            if (expected_strobes.size() == 0) begin
                $display("%0t: unexpected strobe expected none actual rs=%b nibble=%h last=%b",
                         $time, m_reg_select, m_nibble, m_last);
                mismatch_count++;
            end else begin
                exp_s = expected_strobes.pop_front();
                compare_field("reg_select", {3'b0, exp_s.reg_select}, {3'b0, m_reg_select});
                compare_field("nibble", exp_s.nibble, m_nibble);
                compare_field("last", {3'b0, exp_s.last}, {3'b0, m_last});
            end
        end
    end

    // init sequence, twice back to back
    task automatic test_init_sequence();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_request(OP_INIT, 8'h00, 7'h00, 32'h0, 3'd0);
        send_request(OP_INIT, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 3'd7);
        wait_until_idle();
    endtask

    // corner requests of every op
    task automatic test_directed_requests();
        send_request(OP_CMD,     8'h00, 7'h7F, 32'hFFFF_FFFF, 3'd7);
        send_request(OP_CMD,     8'hFF, 7'h00, 32'h0,         3'd0);
        send_request(OP_CMD,     8'h5A, 7'h2A, 32'h1234_5678, 3'd3);
        send_request(OP_CHAR,    8'h00, 7'h7F, 32'hFFFF_FFFF, 3'd7);
        send_request(OP_CHAR,    8'hFF, 7'h00, 32'h0,         3'd0);
        send_request(OP_CHAR,    8'hA5, 7'h55, 32'h0,         3'd2);
        send_request(OP_CURSOR,  8'hFF, 7'h00, 32'h0,         3'd0);
        send_request(OP_CURSOR,  8'h00, 7'h7F, 32'hFFFF_FFFF, 3'd7);
        send_request(OP_CURSOR,  8'h00, 7'h55, 32'h0,         3'd4);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd0,         3'd2);
        send_request(OP_DECIMAL, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 3'd5);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd12345,     3'd5);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd99999,     3'd4);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd100000,    3'd5);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd10,        3'd3);
        // digit counts outside 2..5 saturate
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd7,         3'd0);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd987654,    3'd1);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd4321,      3'd6);
        send_request(OP_DECIMAL, 8'h00, 7'h00, 32'd55555,     3'd7);
        // spare ops make no strobes
        send_request(OP_SPARE_5, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 3'd5);
        send_request(OP_SPARE_6, 8'h12, 7'h34, 32'd56,        3'd2);
        send_request(OP_SPARE_7, 8'h00, 7'h00, 32'd0,         3'd0);
        send_request(OP_CHAR,    8'h41, 7'h00, 32'd0,         3'd0);
        wait_until_idle();
    endtask

    // full rate, no idling on either side
    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random(60);
        wait_until_idle();
    endtask

    // receiver stalls only, so the pipeline backs up
    task automatic test_receiver_backpressure();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        run_random(30);
        wait_until_idle();
    endtask

    // random traffic with idling on both sides and a full drain midway
    task automatic test_random_traffic();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_random(160);
        wait_until_idle();
        run_random(160);
        wait_until_idle();
    endtask

    // main sequence
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_op             = OP_INIT;
        s_byte_value     = 8'h00;
        s_cursor_address = 7'h00;
        s_number         = 32'h0;
        s_digit_count    = 3'd0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_init_sequence();
        test_directed_requests();
        test_back_to_back();
        test_receiver_backpressure();
        test_random_traffic();

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("char_lcd_nibble_write_sequencer_top regression: pass");
        end else begin
            $display("char_lcd_nibble_write_sequencer_top regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("char_lcd_nibble_write_sequencer_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
